/* hw/rtl/cswq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cswq_pkg;

  // fixed field widths
  localparam int OP_W  = 2;
  localparam int ID_W  = 5;
  localparam int PID_W = 5;
  localparam int CNT_W = 8;
  localparam int ST_W  = 3;

  // default sizing
  localparam int SEM_COUNT_DEF  = 32;
  localparam int WAIT_DEPTH_DEF = 16;

  // saturation limit of a count
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  // operation codes
  localparam op_t OP_CREATE = 2'd0;
  localparam op_t OP_LOCK   = 2'd1;
  localparam op_t OP_UNLOCK = 2'd2;

  // status codes
  localparam status_t ST_CREATED   = 3'd0;
  localparam status_t ST_GRANTED   = 3'd1;
  localparam status_t ST_SUSPENDED = 3'd2;
  localparam status_t ST_RELEASED  = 3'd3;
  localparam status_t ST_WOKE      = 3'd4;
  localparam status_t ST_ERROR     = 3'd5;

endpackage

`default_nettype wire

/* hw/rtl/cswq_sem_tbl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cswq_sem_tbl #(
  parameter int ADDR_W  = 5,
  parameter int ENTRY_W = 17
) (
  input  logic                        clk,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [ENTRY_W-1:0]          rd_entry,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [ENTRY_W-1:0]          wr_entry,
  input  logic                        cr_wr_en,
  input  logic [cswq_pkg::PID_W-1:0]  cr_wr_data
);
  import cswq_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  // count, queue head and queue length per semaphore
  logic [ENTRY_W-1:0] entry_mem [DEPTH];
  // creator of each semaphore, kept as a record
  logic [PID_W-1:0]   creator_mem [DEPTH];

  // entry port: registered read, write in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= entry_mem[rd_addr];
  end

  // creator port
  always_ff @(posedge clk) begin
    if (cr_wr_en) begin
      creator_mem[wr_addr] <= cr_wr_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cswq_wait_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cswq_wait_ram #(
  parameter int ADDR_W = 9
) (
  input  logic                        clk,
  input  logic [ADDR_W-1:0]           addr,
  input  logic                        wr_en,
  input  logic [cswq_pkg::PID_W-1:0]  wr_data,
  output logic [cswq_pkg::PID_W-1:0]  rd_data
);
  import cswq_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  // one row of queue slots per semaphore
  logic [PID_W-1:0] slot_mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[addr] <= wr_data;
    end
    rd_data <= slot_mem[addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/counting_semaphore_wait_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// a result strobes on out_valid from the result register, behind the accept stage register
// throughput: one word per cycle; busy stays low, the semaphore table is read in
//   the accept cycle and written back in the next cycle with a bypass for neighbors
// reset: clears the pipeline valids and the id allocator; memories are not swept,
//   an entry is only read after its create has written it
// results cannot be held off by the receiver: each is shown for one cycle only
module counting_semaphore_wait_queue_top #(
  parameter int SEM_COUNT  = cswq_pkg::SEM_COUNT_DEF,
  parameter int WAIT_DEPTH = cswq_pkg::WAIT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cswq_pkg::OP_W-1:0]     in_operation,
  input  logic [cswq_pkg::ID_W-1:0]     in_sem_id,
  input  logic [cswq_pkg::PID_W-1:0]    in_requester,
  input  logic [cswq_pkg::CNT_W-1:0]    in_initial_count,
  output logic                          out_valid,
  output logic [cswq_pkg::ST_W-1:0]     out_status,
  output logic [cswq_pkg::ID_W-1:0]     out_result_id,
  output logic [cswq_pkg::PID_W-1:0]    out_woken_pid,
  output logic [cswq_pkg::CNT_W-1:0]    out_count_after
);
  import cswq_pkg::*;

  localparam int SEM_IW  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam int NID_W   = $clog2(SEM_COUNT + 1);
  localparam int HEAD_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int LEN_W   = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W   = LEN_W + 1;
  localparam int ENTRY_W = CNT_W + HEAD_W + LEN_W;
  localparam int CMP_W   = (NID_W > ID_W) ? NID_W : ID_W;
  localparam int SLOT_AW = SEM_IW + HEAD_W;

  // accept stage registers
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [PID_W-1:0]  s1_who_r;
  logic [CNT_W-1:0]  s1_init_r;

  // id allocator
  logic [NID_W-1:0]  nid_r, nid_nxt;

  // bypass of the last table write
  logic               byp_valid_r;
  logic [SEM_IW-1:0]  byp_addr_r;
  logic [ENTRY_W-1:0] byp_entry_r;

  // result registers
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_result_id_r;
  logic [CNT_W-1:0]  out_count_after_r;

  // table and slot ports
  logic [ENTRY_W-1:0] tbl_rd_entry;
  logic               tbl_we;
  logic               cr_we;
  logic [SEM_IW-1:0]  tbl_wr_addr;
  logic [ENTRY_W-1:0] tbl_wr_entry;
  logic [SLOT_AW-1:0] slot_addr;
  logic               slot_we;
  logic [PID_W-1:0]   slot_rd;

  // decode helpers
  logic [SEM_IW-1:0]  s1_addr;
  logic [ENTRY_W-1:0] cur_entry;
  logic [CNT_W-1:0]   cur_count;
  logic [HEAD_W-1:0]  cur_head;
  logic [LEN_W-1:0]   cur_len;
  logic [SUM_W-1:0]   tail_sum;
  logic [HEAD_W-1:0]  tail;
  logic [HEAD_W-1:0]  head_inc;
  logic               id_known;
  status_t            st_nxt;
  logic [ID_W-1:0]    rid_nxt;
  logic [CNT_W-1:0]   cnt_nxt;

  assign busy = 1'b0;

  // accept stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
    s1_op_r   <= in_operation;
    s1_id_r   <= in_sem_id;
    s1_who_r  <= in_requester;
    s1_init_r <= in_initial_count;
  end

  cswq_sem_tbl #(
    .ADDR_W  (SEM_IW),
    .ENTRY_W (ENTRY_W)
  ) u_sem_tbl (
    .clk        (clk),
    .rd_addr    (SEM_IW'(in_sem_id)),
    .rd_entry   (tbl_rd_entry),
    .wr_en      (tbl_we),
    .wr_addr    (tbl_wr_addr),
    .wr_entry   (tbl_wr_entry),
    .cr_wr_en   (cr_we),
    .cr_wr_data (s1_who_r)
  );

  cswq_wait_ram #(
    .ADDR_W (SLOT_AW)
  ) u_wait_ram (
    .clk     (clk),
    .addr    (slot_addr),
    .wr_en   (slot_we),
    .wr_data (s1_who_r),
    .rd_data (slot_rd)
  );

  // current entry, taking the bypassed table write of the previous word
  assign s1_addr   = SEM_IW'(s1_id_r);
  assign cur_entry = (byp_valid_r && (byp_addr_r == s1_addr)) ? byp_entry_r : tbl_rd_entry;
  assign cur_count = cur_entry[ENTRY_W-1 -: CNT_W];
  assign cur_head  = cur_entry[LEN_W +: HEAD_W];
  assign cur_len   = cur_entry[LEN_W-1:0];

  // queue pointer arithmetic, modulo the queue depth
  assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_len);
  assign tail     = (tail_sum >= SUM_W'(WAIT_DEPTH)) ? HEAD_W'(tail_sum - SUM_W'(WAIT_DEPTH))
                                                     : HEAD_W'(tail_sum);
  assign head_inc = (cur_head == HEAD_W'(WAIT_DEPTH - 1)) ? '0 : cur_head + HEAD_W'(1);

  assign id_known = CMP_W'(s1_id_r) < CMP_W'(nid_r);

  // operation decode and state update
  always_comb begin
    st_nxt       = ST_ERROR;
    rid_nxt      = s1_id_r;
    cnt_nxt      = '0;
    tbl_we       = 1'b0;
    cr_we        = 1'b0;
    tbl_wr_addr  = s1_addr;
    tbl_wr_entry = cur_entry;
    slot_we      = 1'b0;
    slot_addr    = {s1_addr, cur_head};
    nid_nxt      = nid_r;
    case (s1_op_r)
      OP_CREATE: begin
        if (nid_r == NID_W'(SEM_COUNT)) begin
          rid_nxt = '0;
        end else begin
          st_nxt       = ST_CREATED;
          rid_nxt      = ID_W'(nid_r);
          cnt_nxt      = s1_init_r;
          tbl_we       = s1_valid_r;
          cr_we        = s1_valid_r;
          tbl_wr_addr  = SEM_IW'(nid_r);
          tbl_wr_entry = {s1_init_r, {HEAD_W{1'b0}}, {LEN_W{1'b0}}};
          nid_nxt      = s1_valid_r ? nid_r + NID_W'(1) : nid_r;
        end
      end
      OP_LOCK: begin
        if (id_known) begin
          if (cur_count != '0) begin
            st_nxt       = ST_GRANTED;
            cnt_nxt      = cur_count - CNT_W'(1);
            tbl_we       = s1_valid_r;
            tbl_wr_entry = {cnt_nxt, cur_head, cur_len};
          end else if (cur_len == LEN_W'(WAIT_DEPTH)) begin
            cnt_nxt = cur_count;
          end else begin
            st_nxt       = ST_SUSPENDED;
            cnt_nxt      = cur_count;
            tbl_we       = s1_valid_r;
            tbl_wr_entry = {cur_count, cur_head, cur_len + LEN_W'(1)};
            slot_we      = s1_valid_r;
            slot_addr    = {s1_addr, tail};
          end
        end
      end
      OP_UNLOCK: begin
        if (id_known) begin
          if (cur_len == '0) begin
            st_nxt       = ST_RELEASED;
            cnt_nxt      = (cur_count == COUNT_MAX) ? cur_count : cur_count + CNT_W'(1);
            tbl_we       = s1_valid_r;
            tbl_wr_entry = {cnt_nxt, cur_head, cur_len};
          end else begin
            st_nxt       = ST_WOKE;
            cnt_nxt      = cur_count;
            tbl_we       = s1_valid_r;
            tbl_wr_entry = {cur_count, head_inc, cur_len - LEN_W'(1)};
          end
        end
      end
      default: begin
        st_nxt = ST_ERROR;
      end
    endcase
  end

  // allocator, bypass and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nid_r       <= '0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      nid_r       <= nid_nxt;
      byp_valid_r <= tbl_we;
      out_valid_r <= s1_valid_r;
    end
    byp_addr_r        <= tbl_wr_addr;
    byp_entry_r       <= tbl_wr_entry;
    out_status_r      <= st_nxt;
    out_result_id_r   <= rid_nxt;
    out_count_after_r <= cnt_nxt;
  end

  // result word
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_id   = out_result_id_r;
  assign out_count_after = out_count_after_r;
  assign out_woken_pid   = (out_status_r == ST_WOKE) ? slot_rd : '0;

endmodule

`default_nettype wire

/* tb/semaphore_bank_checker.sv */
`timescale 1ns / 1ps

module semaphore_bank_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [cswq_pkg::OP_W-1:0]  in_operation,
  input  logic [cswq_pkg::ID_W-1:0]  in_sem_id,
  input  logic [cswq_pkg::PID_W-1:0] in_requester,
  input  logic [cswq_pkg::CNT_W-1:0] in_initial_count,
  input  logic                       out_valid,
  input  logic [cswq_pkg::ST_W-1:0]  out_status,
  input  logic [cswq_pkg::ID_W-1:0]  out_result_id,
  input  logic [cswq_pkg::PID_W-1:0] out_woken_pid,
  input  logic [cswq_pkg::CNT_W-1:0] out_count_after,
  output int                         fail_count,
  output int                         pending_words
);
  import cswq_pkg::*;

  localparam int SEMS   = SEM_COUNT_DEF;
  localparam int DEPTH  = WAIT_DEPTH_DEF;
  localparam int HEAD_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(SEMS);
  localparam int NID_W  = IDX_W + 1;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  sem;
    logic [PID_W-1:0] woken;
    logic [CNT_W-1:0] count;
  } sem_reply_t;

  // shadow of the semaphore table and its wait rings
  logic [CNT_W-1:0]     count_tbl   [SEMS];
  logic [PID_W-1:0]     creator_tbl [SEMS];
  logic [PID_W-1:0]     waiter_ring [SEMS][DEPTH];
  logic [HEAD_W-1:0]    ring_head   [SEMS];
  logic [HEAD_W:0]      ring_len    [SEMS];
  logic [NID_W-1:0]     next_free_id;

  sem_reply_t expected_replies[$];
  int mismatches = 0;

  // apply one request to the shadow table and return the reply it should give
  function automatic sem_reply_t apply_sem_request(op_t op, logic [ID_W-1:0] sem,
                                                   logic [PID_W-1:0] who,
                                                   logic [CNT_W-1:0] init);
    sem_reply_t r;
    logic [HEAD_W-1:0] slot;
    logic [IDX_W-1:0]  nid;
    r.status = ST_ERROR;
    r.sem    = sem;
    r.woken  = '0;
    r.count  = '0;
    nid      = next_free_id[IDX_W-1:0];
    if (op == OP_CREATE) begin
      r.sem = '0;
      if (next_free_id < NID_W'(SEMS)) begin
        count_tbl[nid]   = init;
        creator_tbl[nid] = who;
        ring_head[nid]   = '0;
        ring_len[nid]    = '0;
        r.status = ST_CREATED;
        r.sem    = next_free_id[ID_W-1:0];
        r.count  = init;
        next_free_id = next_free_id + NID_W'(1);
      end
    end else if ((op == OP_LOCK || op == OP_UNLOCK) && {1'b0, sem} < next_free_id) begin
      if (op == OP_LOCK) begin
        if (count_tbl[sem] != '0) begin
          count_tbl[sem] = count_tbl[sem] - CNT_W'(1);
          r.status = ST_GRANTED;
        end else if (ring_len[sem] < (HEAD_W+1)'(DEPTH)) begin
          slot = ring_head[sem] + ring_len[sem][HEAD_W-1:0];
          waiter_ring[sem][slot] = who;
          ring_len[sem] = ring_len[sem] + (HEAD_W+1)'(1);
          r.status = ST_SUSPENDED;
        end
        // a full ring leaves the error status but reports the count
        r.count = count_tbl[sem];
      end else if (ring_len[sem] == '0) begin
        if (count_tbl[sem] != COUNT_MAX)
          count_tbl[sem] = count_tbl[sem] + CNT_W'(1);
        r.status = ST_RELEASED;
        r.count  = count_tbl[sem];
      end else begin
        r.woken = waiter_ring[sem][ring_head[sem]];
        ring_head[sem] = ring_head[sem] + HEAD_W'(1);
        ring_len[sem]  = ring_len[sem] - (HEAD_W+1)'(1);
        r.status = ST_WOKE;
        r.count  = count_tbl[sem];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sem_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < SEMS; i++) begin
        count_tbl[i]   = '0;
        creator_tbl[i] = '0;
        ring_head[i]   = '0;
        ring_len[i]    = '0;
        for (int j = 0; j < DEPTH; j++)
          waiter_ring[i][j] = '0;
      end
      next_free_id = '0;
      expected_replies.delete();
    end else begin
      // compare a result word against the oldest expectation
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $error("result word with nothing expected: status %0d id %0d", out_status,
                 out_result_id);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_result_id !== want.sem) begin
            $error("result_id: expected %0d, got %0d", want.sem, out_result_id);
            mismatches++;
          end
          if (out_woken_pid !== want.woken) begin
            $error("woken_pid: expected %0d, got %0d", want.woken, out_woken_pid);
            mismatches++;
          end
          if (out_count_after !== want.count) begin
            $error("count_after: expected %0d, got %0d", want.count, out_count_after);
            mismatches++;
          end
        end
      end
      // accepted request word
      if (start && !busy)
        expected_replies.push_back(apply_sem_request(in_operation, in_sem_id, in_requester,
                                                     in_initial_count));
    end
    fail_count    <= mismatches;
    pending_words <= expected_replies.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import cswq_pkg::*;

  // operation code the block does not define
  localparam op_t OP_UNDEFINED = 2'd3;

  localparam int WORD_TARGET = 650;
  localparam int QUIET_FROM  = 200;
  localparam int QUIET_TO    = 350;
  localparam int PAUSE_AT    = 420;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [OP_W-1:0]  in_operation;
  logic [ID_W-1:0]  in_sem_id;
  logic [PID_W-1:0] in_requester;
  logic [CNT_W-1:0] in_initial_count;
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [ID_W-1:0]  out_result_id;
  logic [PID_W-1:0] out_woken_pid;
  logic [CNT_W-1:0] out_count_after;

  int fail_count;
  int pending_words;
  int cycles   = 0;
  int issued   = 0;
  int made_ids = 0;

  counting_semaphore_wait_queue_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_sem_id        (in_sem_id),
    .in_requester     (in_requester),
    .in_initial_count (in_initial_count),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_woken_pid    (out_woken_pid),
    .out_count_after  (out_count_after)
  );

  semaphore_bank_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_sem_id        (in_sem_id),
    .in_requester     (in_requester),
    .in_initial_count (in_initial_count),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_woken_pid    (out_woken_pid),
    .out_count_after  (out_count_after),
    .fail_count       (fail_count),
    .pending_words    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one request word, hold it until taken, then maybe go quiet a while
  task automatic send_word(op_t op, logic [ID_W-1:0] sem, logic [PID_W-1:0] who,
                           logic [CNT_W-1:0] init);
    int gap;
    start            <= 1'b1;
    in_operation     <= op;
    in_sem_id        <= sem;
    in_requester     <= who;
    in_initial_count <= init;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
    if (op == OP_CREATE && made_ids < SEM_COUNT_DEF)
      made_ids++;
    gap = 0;
    if (issued < QUIET_FROM || issued >= QUIET_TO)
      while ($urandom_range(0, 99) < 24) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering words until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    int               kind;
    int               len;
    int               lock_bias;
    logic [ID_W-1:0]  sem;
    logic [CNT_W-1:0] init;
    bit               paused;

    paused           = 1'b0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_operation     <= OP_CREATE;
    in_sem_id        <= '0;
    in_requester     <= '0;
    in_initial_count <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: errors on uncreated ids, both count extremes, wake order, saturation
    send_word(OP_LOCK, 5'd0, 5'd7, 8'd0);
    send_word(OP_UNDEFINED, 5'd31, 5'd31, 8'd255);
    send_word(OP_CREATE, 5'd31, 5'd31, 8'd0);
    send_word(OP_CREATE, 5'd0, 5'd0, 8'd255);
    send_word(OP_CREATE, 5'd9, 5'd21, 8'd1);
    send_word(OP_LOCK, 5'd0, 5'd31, 8'd0);
    send_word(OP_LOCK, 5'd0, 5'd10, 8'd0);
    send_word(OP_UNLOCK, 5'd0, 5'd3, 8'd0);
    send_word(OP_UNLOCK, 5'd0, 5'd3, 8'd0);
    send_word(OP_UNLOCK, 5'd0, 5'd3, 8'd0);
    send_word(OP_LOCK, 5'd0, 5'd4, 8'd0);
    send_word(OP_UNLOCK, 5'd1, 5'd5, 8'd0);
    send_word(OP_LOCK, 5'd1, 5'd5, 8'd0);
    send_word(OP_LOCK, 5'd2, 5'd6, 8'd0);
    send_word(OP_LOCK, 5'd2, 5'd0, 8'd0);
    send_word(OP_UNLOCK, 5'd2, 5'd6, 8'd0);
    send_word(OP_UNLOCK, 5'd31, 5'd1, 8'd0);
    send_word(OP_LOCK, 5'd3, 5'd2, 8'd0);

    // random: creates, lock/unlock bursts on live ids, and raw noise
    while (issued < WORD_TARGET) begin
      if (!paused && issued >= PAUSE_AT) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        case ($urandom_range(0, 3))
          0:       init = '0;
          1:       init = COUNT_MAX;
          2:       init = CNT_W'($urandom_range(0, 4));
          default: init = CNT_W'($urandom_range(0, 255));
        endcase
        send_word(OP_CREATE, ID_W'($urandom_range(0, 31)), PID_W'($urandom_range(0, 31)),
                  init);
      end else if (kind < 50) begin
        send_word(op_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 31)),
                  PID_W'($urandom_range(0, 31)), CNT_W'($urandom_range(0, 255)));
      end else begin
        // bursts lean toward filling or draining one wait ring
        sem = ID_W'($urandom_range(0, made_ids - 1));
        len = $urandom_range(2, 16);
        case ($urandom_range(0, 2))
          0:       lock_bias = 95;
          1:       lock_bias = 70;
          default: lock_bias = 25;
        endcase
        repeat (len)
          send_word(($urandom_range(0, 99) < lock_bias) ? OP_LOCK : OP_UNLOCK, sem,
                    PID_W'($urandom_range(0, 31)), CNT_W'($urandom_range(0, 255)));
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* counting_semaphore_wait_queue_top.f */
hw/rtl/cswq_pkg.sv
hw/rtl/cswq_sem_tbl.sv
hw/rtl/cswq_wait_ram.sv
hw/rtl/counting_semaphore_wait_queue_top.sv
tb/semaphore_bank_checker.sv
tb/tb.sv
